@@ hw/rtl/wswd_pkg.sv @@
// wswd_pkg: shared constants and register codes for the wake score window detector
// depends on nothing; used by wake_score_window_detector_unit
package wswd_pkg;

  localparam int WINDOW_DEFAULT = 8;

  localparam int PROB_W   = 8;
  localparam int TIME_W   = 48;
  localparam int REFR_W   = 24;
  localparam int OSUM_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [PROB_W-1:0] CUTOFF_RESET     = 8'd128;
  localparam logic [PROB_W-1:0] WARMUP_RESET     = 8'd200;
  localparam logic [REFR_W-1:0] REFRACTORY_RESET = 24'd2000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCORE_CUTOFF  = 2'd0,
    REG_WARMUP_RELOAD = 2'd1,
    REG_REFRACTORY    = 2'd2
  } cfg_reg_t;

endpackage

@@ hw/rtl/wake_score_window_detector_unit.sv @@
// wake_score_window_detector_unit: sliding-window mean threshold detector with warmup
// and refractory deadline; depends on wswd_pkg
//
// Accepts one score per cycle unless the output stalls and returns one result per
// score via the s1 and output registers. The last WINDOW scores sit in a small
// synchronous RAM: an item reads its ring slot when accepted and writes it back as it
// leaves stage s1, while the running sum, warmup count, deadline and peak are updated
// in the same cycle; the next item's read is forwarded from that write when both hit
// the same slot. Per-slot valid bits make the ring read as zero after reset and after
// each detection, so there is no clearing pass. The output register lets a new score
// be taken while a result waits. Configuration writes are always ready and take
// effect on the next item; warmup and deadline reload from them only at a detection.
module wake_score_window_detector_unit #(
  parameter int WINDOW = wswd_pkg::WINDOW_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [wswd_pkg::PROB_W-1:0]       probability,
  input  logic [wswd_pkg::TIME_W-1:0]       time_us,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              detected,
  output logic [wswd_pkg::OSUM_W-1:0]       window_sum,
  output logic [wswd_pkg::PROB_W-1:0]       mean_probability,
  output logic                              in_warmup,
  output logic [wswd_pkg::PROB_W-1:0]       peak_probability,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wswd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wswd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_MIN = $clog2(WINDOW * 255 + 1);
  localparam int SUM_W   = (SUM_MIN > wswd_pkg::OSUM_W) ? SUM_MIN : wswd_pkg::OSUM_W;
  localparam int LOG_W   = $clog2(WINDOW);
  localparam int SHIFT   = SUM_W + LOG_W;
  localparam int MUL_W   = SUM_W + 2;
  localparam int PROD_W  = SUM_W + MUL_W + wswd_pkg::PROB_W;
  // rounded-up reciprocal gives an exact quotient for any sum below 2^SUM_W
  localparam logic [63:0] MUL_K64 = ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MUL_W-1:0] MUL_K = MUL_K64[MUL_W-1:0];
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
  localparam logic [SUM_W-1:0] WIN_S = SUM_W'(WINDOW);

  // configuration registers
  logic [wswd_pkg::PROB_W-1:0] score_cutoff;
  logic [wswd_pkg::PROB_W-1:0] warmup_reload;
  logic [wswd_pkg::REFR_W-1:0] refractory_us;

  // ring memory and per-slot valid bits
  logic [wswd_pkg::PROB_W-1:0] ring_mem [0:WINDOW-1];
  logic [WINDOW-1:0]           slot_valid;
  logic [wswd_pkg::PROB_W-1:0] ring_rdata;
  logic                        fwd_hit;
  logic [wswd_pkg::PROB_W-1:0] fwd_data;
  logic [PTR_W-1:0]            rd_ptr;

  // read-modify-write stage
  logic                        s1_valid;
  logic [PTR_W-1:0]            s1_ptr;
  logic [wswd_pkg::PROB_W-1:0] s1_prob;
  logic [wswd_pkg::TIME_W-1:0] s1_time;

  // running state
  logic [SUM_W-1:0]            running_sum;
  logic [wswd_pkg::PROB_W-1:0] warmup_left;
  logic [wswd_pkg::TIME_W-1:0] deadline_us;
  logic [wswd_pkg::PROB_W-1:0] peak_seen;

  logic [SUM_W-1:0]            out_sum;

  logic                        in_xfer;
  logic                        s1_adv;
  logic [wswd_pkg::PROB_W-1:0] old_score;
  logic [SUM_W-1:0]            sum_new;
  logic [SUM_W-1:0]            thresh;
  logic                        warm;
  logic                        fire;
  logic [wswd_pkg::PROB_W-1:0] peak_next;
  logic [PROD_W-1:0]           mean_prod;
  logic [wswd_pkg::TIME_W:0]   dl_sum;
  logic [wswd_pkg::TIME_W-1:0] deadline_next;
  logic [PTR_W-1:0]            rd_ptr_next;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign in_xfer   = in_valid && in_ready;

  assign rd_ptr_next = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;

  always_comb begin
    if (!slot_valid[s1_ptr]) begin
      old_score = '0;
    end else if (fwd_hit) begin
      old_score = fwd_data;
    end else begin
      old_score = ring_rdata;
    end
    sum_new   = running_sum - SUM_W'(old_score) + SUM_W'(s1_prob);
    thresh    = SUM_W'(score_cutoff) * WIN_S;
    warm      = (warmup_left != '0);
    fire      = !warm && (sum_new >= thresh) && (s1_time >= deadline_us);
    peak_next = (s1_prob > peak_seen) ? s1_prob : peak_seen;
    mean_prod = PROD_W'(sum_new) * PROD_W'(MUL_K);
    // deadline saturates at the top of the time range
    dl_sum    = {1'b0, s1_time} + (wswd_pkg::TIME_W + 1)'(refractory_us);
    deadline_next = dl_sum[wswd_pkg::TIME_W] ? '1 : dl_sum[wswd_pkg::TIME_W-1:0];
  end

  // ring memory: written by the finishing item, read by the entering one
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ring_mem[s1_ptr] <= s1_prob;
    end
    if (in_xfer) begin
      ring_rdata <= ring_mem[rd_ptr];
      fwd_hit    <= s1_adv && (s1_ptr == rd_ptr);
      fwd_data   <= s1_prob;
      s1_ptr     <= rd_ptr;
      s1_prob    <= probability;
      s1_time    <= time_us;
    end
    if (s1_adv) begin
      detected         <= fire;
      in_warmup        <= warm;
      out_sum          <= sum_new;
      mean_probability <= mean_prod[SHIFT +: wswd_pkg::PROB_W];
      peak_probability <= peak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score_cutoff  <= wswd_pkg::CUTOFF_RESET;
      warmup_reload <= wswd_pkg::WARMUP_RESET;
      refractory_us <= wswd_pkg::REFRACTORY_RESET;
      slot_valid    <= '0;
      rd_ptr        <= '0;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      running_sum   <= '0;
      warmup_left   <= wswd_pkg::WARMUP_RESET;
      deadline_us   <= wswd_pkg::TIME_W'(wswd_pkg::REFRACTORY_RESET);
      peak_seen     <= '0;
    end else begin
      if (cfg_valid) begin
        case (wswd_pkg::cfg_reg_t'(cfg_index))
          wswd_pkg::REG_SCORE_CUTOFF:  score_cutoff  <= cfg_data[wswd_pkg::PROB_W-1:0];
          wswd_pkg::REG_WARMUP_RELOAD: warmup_reload <= cfg_data[wswd_pkg::PROB_W-1:0];
          wswd_pkg::REG_REFRACTORY:    refractory_us <= cfg_data[wswd_pkg::REFR_W-1:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        rd_ptr <= rd_ptr_next;
      end
      if (in_xfer) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (s1_adv) begin
        peak_seen <= peak_next;
        if (fire) begin
          // detection empties the window
          slot_valid  <= '0;
          running_sum <= '0;
          warmup_left <= warmup_reload;
          deadline_us <= deadline_next;
        end else begin
          slot_valid[s1_ptr] <= 1'b1;
          running_sum        <= sum_new;
          if (warm && (s1_prob < score_cutoff)) begin
            warmup_left <= warmup_left - 1'b1;
          end
        end
      end
    end
  end

  assign window_sum = out_sum[wswd_pkg::OSUM_W-1:0];

  a_no_fire_in_warmup: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(detected && in_warmup))
    else $error("detection reported during warmup");

  a_clear_on_fire: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && fire) |=> (running_sum == '0 && slot_valid == '0))
    else $error("window not cleared after detection");

  // remainder form keeps the upper bound inside the sum width
  a_mean_exact: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (SUM_W'(mean_probability) * WIN_S <= out_sum &&
                   out_sum - SUM_W'(mean_probability) * WIN_S < WIN_S))
    else $error("mean does not match window sum");

  a_peak_grows: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (peak_seen >= $past(peak_seen)))
    else $error("peak decreased");

endmodule

@@ dv/wswd_tb_pkg.sv @@
`timescale 1ns / 1ps
// wswd_tb_pkg: expected-result record and scoreboard for the wake score window detector bench
// depends on wswd_pkg for widths, reset values and register codes
package wswd_tb_pkg;
  import wswd_pkg::*;

  localparam int WINDOW = WINDOW_DEFAULT;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct {
    logic              detected;
    logic [OSUM_W-1:0] window_sum;
    logic [PROB_W-1:0] mean;
    logic              warm;
    logic [PROB_W-1:0] peak;
  } wake_result_t;

  class wake_scoreboard;
    logic [PROB_W-1:0] cutoff;
    logic [PROB_W-1:0] reload;
    logic [REFR_W-1:0] refractory;

    logic [PROB_W-1:0] ring [WINDOW];
    int unsigned       slot;
    int unsigned       total;
    logic [PROB_W-1:0] warmup_left;
    logic [TIME_W-1:0] deadline;
    logic [PROB_W-1:0] peak;

    wake_result_t      expected_results [$];
    int                errors;
    int                scores;
    int                detections;
    int                warm_scores;
    int                reg_writes;

    function new();
      cutoff      = CUTOFF_RESET;
      reload      = WARMUP_RESET;
      refractory  = REFRACTORY_RESET;
      foreach (ring[i]) ring[i] = '0;
      slot        = 0;
      total       = 0;
      warmup_left = WARMUP_RESET;
      deadline    = TIME_W'(REFRACTORY_RESET);
      peak        = '0;
      errors      = 0;
      scores      = 0;
      detections  = 0;
      warm_scores = 0;
      reg_writes  = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_SCORE_CUTOFF: begin
          cutoff = data[PROB_W-1:0];
        end
        REG_WARMUP_RELOAD: begin
          reload = data[PROB_W-1:0];
        end
        REG_REFRACTORY: begin
          refractory = data[REFR_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // predict the result of one accepted score
    function void note_score(logic [PROB_W-1:0] p, logic [TIME_W-1:0] t);
      wake_result_t r;
      int unsigned  s;
      logic [TIME_W:0] d;
      scores++;
      if (p > peak) peak = p;
      total      = total - ring[slot] + p;
      ring[slot] = p;
      slot       = (slot + 1) % WINDOW;
      s          = total;
      r.detected   = 1'b0;
      r.warm       = 1'b0;
      r.window_sum = OSUM_W'(s);
      r.mean       = PROB_W'(s / WINDOW);
      if (warmup_left != 0) begin
        r.warm = 1'b1;
        warm_scores++;
        if (p < cutoff) warmup_left--;
      end else if (s >= int'(cutoff) * WINDOW && t >= deadline) begin
        r.detected = 1'b1;
        detections++;
        // deadline saturates at the top of the time range
        d = {1'b0, t} + (TIME_W + 1)'(refractory);
        deadline = d[TIME_W] ? TIME_MAX : d[TIME_W-1:0];
        warmup_left = reload;
        foreach (ring[i]) ring[i] = '0;
        total = 0;
      end
      r.peak = peak;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [OSUM_W-1:0] want, logic [OSUM_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic det, logic [OSUM_W-1:0] sum, logic [PROB_W-1:0] mean,
                               logic warm, logic [PROB_W-1:0] pk);
      wake_result_t e;
      if (expected_results.size() == 0) begin
        $error("result transfer with no score waiting for it");
        errors++;
        return;
      end
      e = expected_results.pop_front();
      compare_field("detected", OSUM_W'(e.detected), OSUM_W'(det));
      compare_field("window_sum", e.window_sum, sum);
      compare_field("mean_probability", OSUM_W'(e.mean), OSUM_W'(mean));
      compare_field("in_warmup", OSUM_W'(e.warm), OSUM_W'(warm));
      compare_field("peak_probability", OSUM_W'(e.peak), OSUM_W'(pk));
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: random and directed bench for wake_score_window_detector_unit
// depends on wswd_pkg and wswd_tb_pkg (scoreboard)
module tb_top;
  import wswd_pkg::*;
  import wswd_tb_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 10;
  localparam int DIRECTED      = 12;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [PROB_W-1:0]     probability;
  logic [TIME_W-1:0]     time_us;
  logic                  out_valid;
  logic                  out_ready;
  logic                  detected;
  logic [OSUM_W-1:0]     window_sum;
  logic [PROB_W-1:0]     mean_probability;
  logic                  in_warmup;
  logic [PROB_W-1:0]     peak_probability;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wake_scoreboard sb;
  int             send_idle_pct;
  int             recv_stall_pct;
  int             burst_left;
  int             cycles = 0;
  logic [TIME_W-1:0] now_us;

  // all of these land while warmup holds detection off
  logic [PROB_W-1:0] dir_prob [DIRECTED] = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd1, 8'd254,
                                             8'h55, 8'hAA, 8'd0, 8'd255, 8'd128, 8'd127};
  logic [TIME_W-1:0] dir_time [DIRECTED] = '{48'd0, 48'hFFFF_FFFF_FFFF, 48'h5555_5555_5555,
                                             48'hAAAA_AAAA_AAAA, 48'd1, 48'd2000000,
                                             48'd1999999, 48'd3, 48'hFFFF_FFFF_FFFE,
                                             48'd0, 48'd2000001, 48'd10};

  wake_score_window_detector_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .probability      (probability),
    .time_us          (time_us),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .detected         (detected),
    .window_sum       (window_sum),
    .mean_probability (mean_probability),
    .in_warmup        (in_warmup),
    .peak_probability (peak_probability),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(detected, window_sum, mean_probability, in_warmup, peak_probability);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // leaves valid high after the transfer; the next call or the caller lowers it
  task automatic send_score(logic [PROB_W-1:0] p, logic [TIME_W-1:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    probability <= p;
    time_us     <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_score(p, t);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // byte registers get junk in the unused upper bits
  task automatic configure(logic [PROB_W-1:0] cutoff, logic [PROB_W-1:0] reload,
                           logic [REFR_W-1:0] refr, bit poke_unused);
    logic [CFG_DATA_W-PROB_W-1:0] junk;
    go_idle();
    junk = (CFG_DATA_W - PROB_W)'($urandom);
    write_reg(REG_SCORE_CUTOFF, {junk, cutoff});
    junk = (CFG_DATA_W - PROB_W)'($urandom);
    write_reg(REG_WARMUP_RELOAD, {junk, reload});
    write_reg(REG_REFRACTORY, refr);
    if (poke_unused) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // run the warmup count out with low scores under the highest cutoff
  task automatic clear_warmup();
    configure(8'd255, 8'd0, sb.refractory, 1'b0);
    while (sb.warmup_left != 0) send_score(8'd0, now_us);
  endtask

  task automatic random_scores(int n);
    logic [PROB_W-1:0] p;
    logic [TIME_W-1:0] t;
    int unsigned       back;
    int                r;
    repeat (n) begin
      if (sb.warmup_left != 0) begin
        burst_left = 0;
        if (sb.cutoff != 0 && $urandom_range(0, 3) != 0)
          p = PROB_W'($urandom_range(0, sb.cutoff - 1));
        else p = PROB_W'($urandom_range(0, 255));
      end else begin
        if (burst_left == 0 && $urandom_range(0, 5) == 0)
          burst_left = $urandom_range(WINDOW, WINDOW + 4);
        if (burst_left != 0) begin
          p = PROB_W'($urandom_range(sb.cutoff, 255));
          burst_left--;
        end else begin
          p = PROB_W'($urandom_range(0, 255));
        end
      end
      r = $urandom_range(0, 99);
      if (sb.warmup_left != 0 && r < 5) begin
        // far-off times are harmless while warmup blocks detection
        t = {16'($urandom), $urandom};
      end else if (r < 10) begin
        back = $urandom_range(0, 3000000);
        t = (now_us > back) ? now_us - back : '0;
      end else begin
        now_us = now_us + $urandom_range(0, sb.refractory / 6 + 200000);
        t = now_us;
      end
      send_score(p, t);
    end
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    probability    = '0;
    time_us        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_SCORE_CUTOFF;
    cfg_data       = '0;
    now_us         = '0;
    burst_left     = 0;
    send_idle_pct  = 29;
    recv_stall_pct = 77;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: extremes during warmup, then random scores
    for (int i = 0; i < DIRECTED; i++) send_score(dir_prob[i], dir_time[i]);
    random_scores(300);

    clear_warmup();
    configure(8'd0, 8'd0, 24'd0, 1'b0);
    random_scores(60);

    configure(8'd255, 8'd3, 24'd500000, 1'b0);
    random_scores(420);

    send_idle_pct  = 77;
    recv_stall_pct = 29;
    configure(8'($urandom_range(1, 255)), 8'($urandom_range(0, 20)),
              24'($urandom_range(0, 4000000)), 1'b0);
    random_scores(300);

    configure(8'd128, 8'd200, 24'hFF_FFFF, 1'b0);
    random_scores(300);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(8'($urandom_range(1, 255)), 8'($urandom_range(0, 10)), 24'($urandom), 1'b1);
    random_scores(300);

    // deadline saturation at the top of the time range, then time going back
    clear_warmup();
    configure(8'd0, 8'd0, 24'hFF_FFFF, 1'b0);
    send_score(8'd200, TIME_MAX - 48'd100);
    send_score(8'd7, TIME_MAX);
    send_score(8'd0, 48'd5);
    send_score(8'd255, TIME_MAX - 48'd1);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("scores sent: %0d, detections: %0d, held off by warmup: %0d",
             sb.scores, sb.detections, sb.warm_scores);
    $display("register writes: %0d across cutoff, warmup and refractory extremes",
             sb.reg_writes);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/wswd_pkg.sv
hw/rtl/wake_score_window_detector_unit.sv
dv/wswd_tb_pkg.sv
dv/tb_top.sv
